[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/tsbc_pkg.sv]
// ----------------------------------------------------------------------------
// tsbc_pkg
// Types, codes and control program of the tiny S-box block cipher.
// ----------------------------------------------------------------------------
package tsbc_pkg;

    localparam int ROUNDS = 3;
    localparam int RND_W  = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam int NUM_KEYS = 3;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_ENCRYPT = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    localparam logic [7:0] RCON_1 = 8'h80;
    localparam logic [7:0] RCON_2 = 8'h30;

    // program steps
    localparam logic [1:0] STEP_K1    = 2'd0;
    localparam logic [1:0] STEP_K2    = 2'd1;
    localparam logic [1:0] STEP_RND0  = 2'd2;
    localparam logic [1:0] STEP_ROUND = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  entry_index;
        logic [7:0]  entry_value;
        logic [15:0] plaintext;
    } t_in_item;

    typedef struct packed {
        logic [15:0] ciphertext;
        logic [15:0] second_round_key;
        logic [15:0] third_round_key;
    } t_out_item;

    typedef enum logic [1:0] {
        ADDR_K1  = 2'd0,
        ADDR_K2  = 2'd1,
        ADDR_RND = 2'd2
    } t_addr_sel;

    typedef struct packed {
        t_addr_sel  addr_sel;
        logic       ld_k1;
        logic       ld_k2;
        logic       ld_blk;
        logic       loop;   // jump to jmp while rounds remain
        logic       fin;    // last round done here
        logic [1:0] jmp;
        logic [1:0] nxt;
    } t_ctrl;

    function automatic t_ctrl ctrl_rom(input logic [1:0] step);
        t_ctrl c;
        c = '0;
        unique case (step)
            STEP_K1: begin
                c.addr_sel = ADDR_K1;
                c.nxt      = STEP_K2;
            end
            STEP_K2: begin
                c.addr_sel = ADDR_K2;
                c.ld_k1    = 1'b1;
                c.nxt      = STEP_RND0;
            end
            STEP_RND0: begin
                c.addr_sel = ADDR_RND;
                c.ld_k2    = 1'b1;
                c.nxt      = STEP_ROUND;
            end
            STEP_ROUND: begin
                c.addr_sel = ADDR_RND;
                c.ld_blk   = 1'b1;
                c.loop     = 1'b1;
                c.fin      = 1'b1;
                c.jmp      = STEP_ROUND;
                c.nxt      = STEP_K1;
            end
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] nib_swap(input logic [7:0] b);
        return {b[3:0], b[7:4]};
    endfunction

endpackage

[sv/tiny_sbox_block_cipher.sv]
// ----------------------------------------------------------------------------
// tiny_sbox_block_cipher
// 16-bit toy cipher with loadable 256x8 S-box, run by a small control ROM.
// ----------------------------------------------------------------------------
//  channel   signals                              direction
//  in        i_in_valid / o_in_stall / i_in_data  item in (write, encrypt, clear)
//  out       o_out_valid / i_out_stall / o_out_data  result out (encrypt only)
//  cfg       i_cfg_valid / o_cfg_ready / i_cfg_data  secret key write
//
//  Write and clear items do not set the sequencer busy. An encrypt item holds the input
//  (o_in_stall) for two key lookups and ROUNDS round lookups, each a dependent
//  read through the registered S-box read ports.
//  Reset (sync, active low) clears the S-box valid bits, key and control.
//  A stalled output holds the sequencer at its final step until taken.
// ----------------------------------------------------------------------------
module tiny_sbox_block_cipher
    import tsbc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

`include "assert_macros.svh"

    logic [15:0]      r_key;
    logic [7:0]       r_sbox [256];
    logic [255:0]     r_sbox_v;
    logic             r_busy;
    logic [1:0]       r_step;
    logic [RND_W-1:0] r_rnd;
    logic [1:0]       r_kidx;
    logic [15:0]      r_blk;
    logic [7:0]       r_w2, r_w3, r_w4, r_w5;
    logic [7:0]       r_rd_hi, r_rd_lo;
    logic             r_rd_hi_v, r_rd_lo_v;
    logic             r_out_valid;
    t_out_item        r_out;

    t_ctrl            w_ctrl;
    logic             w_acc, w_last, w_adv;
    logic [15:0]      w_sub;
    logic [7:0]       n_w2, n_w3, n_w4, n_w5;
    logic [15:0]      n_blk;
    logic [1:0]       w_kidx_nxt, w_kidx_use;
    logic [15:0]      w_rkey, w_mix;
    logic [7:0]       w_addr_hi, w_addr_lo;

    assign w_acc       = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_busy;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_ctrl = ctrl_rom(r_step);
    assign w_last = (r_rnd == RND_W'(ROUNDS - 1));
    // only the final step can wait, on a full output register
    assign w_adv  = r_busy && !(w_ctrl.fin && w_last && r_out_valid && i_out_stall);

    // unwritten or cleared entries read as zero
    assign w_sub = {r_rd_hi_v ? r_rd_hi : 8'h00, r_rd_lo_v ? r_rd_lo : 8'h00};

    assign n_w2  = r_key[15:8] ^ RCON_1 ^ w_sub[7:0];
    assign n_w3  = n_w2 ^ r_key[7:0];
    assign n_w4  = r_w2 ^ RCON_2 ^ w_sub[7:0];
    assign n_w5  = n_w4 ^ r_w3;
    assign n_blk = w_ctrl.ld_blk ? w_sub : r_blk;

    assign w_kidx_nxt = (r_kidx == 2'(NUM_KEYS - 1)) ? 2'd0 : r_kidx + 2'd1;
    assign w_kidx_use = w_ctrl.ld_blk ? w_kidx_nxt : r_kidx;

    always_comb begin
        unique case (w_kidx_use)
            2'd1:    w_rkey = {r_w2, r_w3};
            2'd2:    w_rkey = {r_w4, r_w5};
            default: w_rkey = r_key;
        endcase
    end

    assign w_mix = n_blk ^ w_rkey;

    always_comb begin
        unique case (w_ctrl.addr_sel)
            ADDR_K1: begin
                w_addr_hi = 8'h00;
                w_addr_lo = nib_swap(r_key[7:0]);
            end
            ADDR_K2: begin
                w_addr_hi = 8'h00;
                w_addr_lo = nib_swap(n_w3);
            end
            default: begin
                w_addr_hi = w_mix[15:8];
                w_addr_lo = w_mix[7:0];
            end
        endcase
    end

    // S-box storage, no reset
    always_ff @(posedge i_clk) begin
        if (w_acc && i_in_data.op == OP_WRITE) begin
            r_sbox[i_in_data.entry_index] <= i_in_data.entry_value;
        end
        if (w_adv) begin
            r_rd_hi <= r_sbox[w_addr_hi];
            r_rd_lo <= r_sbox[w_addr_lo];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sbox_v  <= '0;
            r_rd_hi_v <= 1'b0;
            r_rd_lo_v <= 1'b0;
        end else begin
            if (w_acc && i_in_data.op == OP_WRITE) begin
                r_sbox_v[i_in_data.entry_index] <= 1'b1;
            end else if (w_acc && i_in_data.op == OP_CLEAR) begin
                r_sbox_v <= '0;
            end
            if (w_adv) begin
                r_rd_hi_v <= r_sbox_v[w_addr_hi];
                r_rd_lo_v <= r_sbox_v[w_addr_lo];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_key <= i_cfg_data;
        end
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= STEP_K1;
            r_rnd       <= '0;
            r_kidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_acc && i_in_data.op == OP_ENCRYPT) begin
                r_busy <= 1'b1;
                r_step <= STEP_K1;
                r_rnd  <= '0;
                r_kidx <= '0;
            end else if (w_adv) begin
                if (w_ctrl.loop && !w_last) begin
                    r_step <= w_ctrl.jmp;
                end else begin
                    r_step <= w_ctrl.nxt;
                end
                if (w_ctrl.ld_blk && !w_last) begin
                    r_rnd  <= r_rnd + RND_W'(1);
                    r_kidx <= w_kidx_nxt;
                end
                if (w_ctrl.fin && w_last) begin
                    r_busy      <= 1'b0;
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_acc && i_in_data.op == OP_ENCRYPT) begin
            r_blk <= i_in_data.plaintext;
        end else if (w_adv) begin
            if (w_ctrl.ld_k1) begin
                r_w2 <= n_w2;
                r_w3 <= n_w3;
            end
            if (w_ctrl.ld_k2) begin
                r_w4 <= n_w4;
                r_w5 <= n_w5;
            end
            if (w_ctrl.ld_blk) begin
                r_blk <= n_blk;
            end
            if (w_ctrl.fin && w_last) begin
                r_out.ciphertext       <= n_blk;
                r_out.second_round_key <= {r_w2, r_w3};
                r_out.third_round_key  <= {r_w4, r_w5};
            end
        end
    end

    `AST_IMPL(a_out_from_seq, i_clk, i_rst_n, $rose(r_out_valid), $past(r_busy))
    `AST_IMPL(a_wait_final, i_clk, i_rst_n, r_busy && !w_adv, (r_step == STEP_ROUND) && w_last)
    `AST_IMPL(a_rnd_bound, i_clk, i_rst_n, r_busy, (r_rnd <= RND_W'(ROUNDS - 1)) && (r_kidx <= 2'd2))
    `AST_NEXT(a_done_idle, i_clk, i_rst_n, w_adv && w_ctrl.fin && w_last, !r_busy && r_out_valid)

endmodule
